// ===== hdl/idsb_pkg.sv =====
// shared types and constants for the image downscaler
`default_nettype none

package idsb_pkg;

	localparam int LANES     = 4;
	localparam int CHAN_W    = 8;
	localparam int LANE_W    = 9;
	localparam int DIM_W     = 14;
	localparam int CC_W      = 3;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TGT_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TGT_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHAN_COUNT = 3'd4;

	typedef logic [LANES-1:0][CHAN_W-1:0] pix_t;
	typedef logic [LANES-1:0][LANE_W-1:0] lane_sum_t;

	// clamped geometry as used by the datapath
	typedef struct packed {
		logic [DIM_W-1:0] sw;
		logic [DIM_W-1:0] sh;
		logic [DIM_W-1:0] tw;
		logic [DIM_W-1:0] th;
		logic [CC_W-1:0]  cc;
		logic             half;
	} geom_t;

	// position status for the pixel in the work stage
	typedef struct packed {
		logic [DIM_W-1:0] col;
		logic             col_odd;
		logic             row_odd;
		logic             row_end;
		logic             frame_end;
		logic             pick;
		logic             pick_last;
	} pos_t;

	typedef struct packed {
		pix_t chan;
		logic last;
	} result_t;

endpackage

`default_nettype wire

// ===== hdl/idsb_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none

module idsb_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 4096
) (
	input  wire                         clk,
	input  wire                         wr_en,
	input  wire  [$clog2(DEPTH)-1:0]    wr_addr,
	input  wire  [WIDTH-1:0]            wr_data,
	input  wire                         rd_en,
	input  wire  [$clog2(DEPTH)-1:0]    rd_addr,
	output logic [WIDTH-1:0]            rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/idsb_pos.sv =====
// source and target position tracking, nearest pick by error accumulators
`default_nettype none

module idsb_pos (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  restart,
	input  wire                  step,
	input  wire idsb_pkg::geom_t geom,
	output idsb_pkg::pos_t       pos
);

	localparam int W = idsb_pkg::DIM_W;

	logic [W-1:0] src_col_q, src_row_q, tgt_col_q, tgt_row_q;
	// t*sw - c*tw along a row, t*sh - r*th down the frame
	logic [W-1:0] dc_q, dr_q;

	logic row_pick;

	always_comb begin
		row_pick      = (dr_q < geom.th);
		pos.col       = src_col_q;
		pos.col_odd   = src_col_q[0];
		pos.row_odd   = src_row_q[0];
		pos.row_end   = (({1'b0, src_col_q} + 15'd1) >= {1'b0, geom.sw});
		pos.frame_end = pos.row_end && (({1'b0, src_row_q} + 15'd1) >= {1'b0, geom.sh});
		pos.pick      = !geom.half && row_pick && (dc_q < geom.tw);
		pos.pick_last = (({1'b0, tgt_col_q} + 15'd1) == {1'b0, geom.tw}) &&
			(({1'b0, tgt_row_q} + 15'd1) == {1'b0, geom.th});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			src_row_q <= '0;
			tgt_col_q <= '0;
			tgt_row_q <= '0;
			dc_q      <= '0;
			dr_q      <= '0;
		end else if (restart || (step && pos.frame_end)) begin
			src_col_q <= '0;
			src_row_q <= '0;
			tgt_col_q <= '0;
			tgt_row_q <= '0;
			dc_q      <= '0;
			dr_q      <= '0;
		end else if (step) begin
			if (pos.row_end) begin
				src_col_q <= '0;
				tgt_col_q <= '0;
				dc_q      <= '0;
				src_row_q <= src_row_q + W'(1);
				if (!geom.half) begin
					if (row_pick) begin
						tgt_row_q <= tgt_row_q + W'(1);
						dr_q      <= W'({1'b0, dr_q} + {1'b0, geom.sh} - {1'b0, geom.th});
					end else begin
						dr_q <= dr_q - geom.th;
					end
				end
			end else begin
				src_col_q <= src_col_q + W'(1);
				if (pos.pick) begin
					tgt_col_q <= tgt_col_q + W'(1);
					dc_q      <= W'({1'b0, dc_q} + {1'b0, geom.sw} - {1'b0, geom.tw});
				end else if (!geom.half && row_pick) begin
					dc_q <= dc_q - geom.tw;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/idsb_box.sv =====
// 2x2 box filter: pair hold, line store of even-row pair sums, rounded mean
`default_nettype none

module idsb_box #(
	parameter int MAX_WIDTH = 8192
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  restart,
	input  wire                  step,
	input  wire                  half,
	input  wire idsb_pkg::pos_t  pos,
	input  wire idsb_pkg::pix_t  px,
	output idsb_pkg::pix_t       mean
);

	localparam int DEPTH = MAX_WIDTH / 2;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int WORD_W = idsb_pkg::LANES * idsb_pkg::LANE_W;

	idsb_pkg::lane_sum_t hold_q;
	idsb_pkg::lane_sum_t pair_sum;
	idsb_pkg::lane_sum_t line_rd;
	logic [WORD_W-1:0]   rd_word;
	logic [IDX_W-1:0]    idx;
	logic                wr_en, rd_en;
	logic [10:0]         total;

	assign idx   = pos.col[IDX_W:1];
	assign wr_en = step && half && pos.col_odd && !pos.row_odd;
	assign rd_en = step && half && !pos.col_odd && pos.row_odd;
	assign line_rd = idsb_pkg::lane_sum_t'(rd_word);

	always_comb begin
		total = '0;
		for (int k = 0; k < idsb_pkg::LANES; k++) begin
			pair_sum[k] = hold_q[k] + {1'b0, px[k]};
			total       = {2'b00, line_rd[k]} + {2'b00, hold_q[k]} + {3'b000, px[k]} + 11'd2;
			mean[k]     = total[9:2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
		end else if (restart) begin
			hold_q <= '0;
		end else if (step && half && !pos.col_odd) begin
			for (int k = 0; k < idsb_pkg::LANES; k++) begin
				hold_q[k] <= {1'b0, px[k]};
			end
		end
	end

	idsb_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_line (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (idx),
		.wr_data (WORD_W'(pair_sum)),
		.rd_en   (rd_en),
		.rd_addr (idx),
		.rd_data (rd_word)
	);

endmodule

`default_nettype wire

// ===== hdl/image_downscale_nearest_or_box2x_top.sv =====
// top level of the nearest-neighbour / 2x2 box image downscaler
// at most one target pixel per source pixel, which passes the input and result registers
// throughput: one source pixel per clock while the skid slot is free, set by the input
// register to result register pass and one line store access per pixel
// reset (arst_n low, asynchronous): counters, pair hold and handshakes cleared, registers
// back to 1/1/1/1/4 channels; the line store is not cleared, even rows fill it before use
`default_nettype none

module image_downscale_nearest_or_box2x_top #(
	parameter int MAX_WIDTH = 8192
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// configuration write channel
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [idsb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [idsb_pkg::DIM_W-1:0]          cfg_data,
	// source pixel channel
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire  [idsb_pkg::CHAN_W-1:0]         in_chan0,
	input  wire  [idsb_pkg::CHAN_W-1:0]         in_chan1,
	input  wire  [idsb_pkg::CHAN_W-1:0]         in_chan2,
	input  wire  [idsb_pkg::CHAN_W-1:0]         in_chan3,
	// target pixel channel
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [idsb_pkg::CHAN_W-1:0]         out_chan0,
	output logic [idsb_pkg::CHAN_W-1:0]         out_chan1,
	output logic [idsb_pkg::CHAN_W-1:0]         out_chan2,
	output logic [idsb_pkg::CHAN_W-1:0]         out_chan3,
	output logic                                frame_last
);

	localparam int W = idsb_pkg::DIM_W;
	localparam logic [W:0] MAX_W15 = (W+1)'(MAX_WIDTH);

	// raw register file
	logic [W-1:0]              src_w_q, src_h_q, tgt_w_q, tgt_h_q;
	logic [idsb_pkg::CC_W-1:0] chan_cnt_q;
	idsb_pkg::geom_t           geom_q;
	idsb_pkg::geom_t           geom_d;
	logic                      cfg_hit, restart;

	// input register
	logic                      valid_s1;
	idsb_pkg::pix_t            chan_s1;

	// work stage
	logic                      step;
	idsb_pkg::pix_t            px;
	idsb_pkg::pix_t            mean;
	idsb_pkg::pos_t            pos;
	logic                      res_valid;
	idsb_pkg::result_t         res;

	// result register with skid slot behind it
	idsb_pkg::result_t         out_q, skid_q;
	logic                      out_valid_q, skid_valid_q;

	// ---------------- configuration ----------------
	// writes are always taken; any known register restarts the frame
	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index <= idsb_pkg::REG_CHAN_COUNT);
	assign restart   = cfg_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q    <= W'(1);
			src_h_q    <= W'(1);
			tgt_w_q    <= W'(1);
			tgt_h_q    <= W'(1);
			chan_cnt_q <= idsb_pkg::CC_W'(4);
		end else if (cfg_valid) begin
			case (cfg_index)
				idsb_pkg::REG_SRC_WIDTH:  src_w_q    <= cfg_data;
				idsb_pkg::REG_SRC_HEIGHT: src_h_q    <= cfg_data;
				idsb_pkg::REG_TGT_WIDTH:  tgt_w_q    <= cfg_data;
				idsb_pkg::REG_TGT_HEIGHT: tgt_h_q    <= cfg_data;
				idsb_pkg::REG_CHAN_COUNT: chan_cnt_q <= cfg_data[idsb_pkg::CC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// clamp the geometry: zero acts as one, source width saturates, target never above source
	always_comb begin
		logic [W:0] sw, tw0, th0, sh;
		sw = (src_w_q == '0) ? (W+1)'(1) : {1'b0, src_w_q};
		if (sw > MAX_W15) begin
			sw = MAX_W15;
		end
		sh  = (src_h_q == '0) ? (W+1)'(1) : {1'b0, src_h_q};
		tw0 = (tgt_w_q == '0) ? (W+1)'(1) : {1'b0, tgt_w_q};
		th0 = (tgt_h_q == '0) ? (W+1)'(1) : {1'b0, tgt_h_q};
		if (tw0 > sw) begin
			tw0 = sw;
		end
		if (th0 > sh) begin
			th0 = sh;
		end
		geom_d.sw   = sw[W-1:0];
		geom_d.sh   = sh[W-1:0];
		geom_d.tw   = tw0[W-1:0];
		geom_d.th   = th0[W-1:0];
		geom_d.half = (sw == {tw0[W-1:0], 1'b0}) && (sh == {th0[W-1:0], 1'b0});
		if (chan_cnt_q == '0) begin
			geom_d.cc = idsb_pkg::CC_W'(1);
		end else if (chan_cnt_q > idsb_pkg::CC_W'(idsb_pkg::LANES)) begin
			geom_d.cc = idsb_pkg::CC_W'(idsb_pkg::LANES);
		end else begin
			geom_d.cc = chan_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.sw   <= W'(1);
			geom_q.sh   <= W'(1);
			geom_q.tw   <= W'(1);
			geom_q.th   <= W'(1);
			geom_q.cc   <= idsb_pkg::CC_W'(4);
			geom_q.half <= 1'b0;
		end else begin
			geom_q <= geom_d;
		end
	end

	// ---------------- input register ----------------
	// the work stage moves whenever the skid slot is free
	assign step     = valid_s1 && !skid_valid_q;
	assign in_ready = !valid_s1 || !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			chan_s1 <= {in_chan3, in_chan2, in_chan1, in_chan0};
		end
	end

	// ---------------- work stage ----------------
	// lanes at or beyond the channel count read as zero
	always_comb begin
		for (int k = 0; k < idsb_pkg::LANES; k++) begin
			px[k] = (idsb_pkg::CC_W'(k) < geom_q.cc) ? chan_s1[k] : '0;
		end
	end

	idsb_pos u_pos (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.step    (step),
		.geom    (geom_q),
		.pos     (pos)
	);

	idsb_box #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_box (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.step    (step),
		.half    (geom_q.half),
		.pos     (pos),
		.px      (px),
		.mean    (mean)
	);

	// box mode yields on the odd pixel of an odd row, nearest mode on a picked pixel
	always_comb begin
		res_valid = step && (geom_q.half ? (pos.col_odd && pos.row_odd) : pos.pick);
		res.chan  = geom_q.half ? mean : px;
		res.last  = geom_q.half ? pos.frame_end : pos.pick_last;
	end

	// ---------------- output register and skid ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_chan0  = out_q.chan[0];
	assign out_chan1  = out_q.chan[1];
	assign out_chan2  = out_q.chan[2];
	assign out_chan3  = out_q.chan[3];
	assign frame_last = out_q.last;

endmodule

`default_nettype wire

// ===== hdl/idsb_chk.sv =====
// port-level checker for the downscaler, bound to the top level
`default_nettype none

module idsb_chk (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          in_ready,
	input wire                          out_valid,
	input wire                          out_ready,
	input wire [idsb_pkg::CHAN_W-1:0]   out_chan0,
	input wire [idsb_pkg::CHAN_W-1:0]   out_chan1,
	input wire [idsb_pkg::CHAN_W-1:0]   out_chan2,
	input wire [idsb_pkg::CHAN_W-1:0]   out_chan3,
	input wire                          frame_last
);

	// a stalled result request holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_chan0) && $stable(out_chan1) &&
			$stable(out_chan2) && $stable(out_chan3) && $stable(frame_last))
		else $error("result changed while stalled");

	// a result request is only withdrawn by a handshake
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result dropped without handshake");

	// source side only stalls when a result is backed up
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no pending result");

	// draining the result frees the input side in the next cycle
	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && out_ready |=> in_ready)
		else $error("input still stalled after result taken");

endmodule

bind image_downscale_nearest_or_box2x_top idsb_chk u_idsb_chk (.*);

`default_nettype wire
